/* rtl/core/lcsi_pkg.sv */
// Package for the lattice coordinate to site index block.
// Holds beat types, configuration bundle, register codes and the extent decode.
// No dependencies.
package lcsi_pkg;

  localparam int unsigned ExtW    = 12;
  localparam int unsigned PackW   = 48;
  localparam int unsigned MaxDims = 4;

  localparam logic [PackW-1:0] ExtReset = 48'h001001001001;

  typedef enum logic [2:0] {
    REG_RANK_EXT  = 3'd0,
    REG_LOCAL_EXT = 3'd1,
    REG_INNER_EXT = 3'd2,
    REG_OUTER_EXT = 3'd3,
    REG_CB_SHIFT  = 3'd4,
    REG_CB_DIR    = 3'd5,
    REG_OUTER_SZ  = 3'd6,
    REG_INNER_SZ  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [ExtW-1:0] coord_3;
    logic [ExtW-1:0] coord_2;
    logic [ExtW-1:0] coord_1;
    logic [ExtW-1:0] coord_0;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] owner_rank;
    logic [23:0] site_index;
  } out_beat_t;

  typedef struct packed {
    logic [PackW-1:0] rank_extents;
    logic [PackW-1:0] local_extents;
    logic [PackW-1:0] inner_extents;
    logic [PackW-1:0] outer_extents;
    logic [10:0]      cb_shift;
    logic [1:0]       cb_direction;
    logic [24:0]      outer_sites;
    logic [12:0]      inner_sites;
  } cfg_t;

  // Pick one 12-bit extent field; a zero field counts as one.
  function automatic logic [ExtW-1:0] ext_of(logic [PackW-1:0] p, int unsigned dim);
    logic [ExtW-1:0] e;
    e = p[ExtW*dim +: ExtW];
    return (e == '0) ? ExtW'(1) : e;
  endfunction

endpackage

/* rtl/core/lcsi_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with payload delay.
// Divisor must be held static by the user while beats are in flight; not enforced here. Uses lcsi_pkg.
module lcsi_div
  import lcsi_pkg::*;
#(
  parameter int unsigned W  = 12,
  parameter int unsigned PW = 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [W-1:0]    dividend_i,
  input  logic [ExtW-1:0] divisor_i,
  input  logic [PW-1:0]   pay_i,
  output logic [W-1:0]    quot_o,
  output logic [ExtW-1:0] rem_o,
  output logic [PW-1:0]   pay_o
);

  logic [ExtW-1:0] r_q [W];
  logic [W-1:0]    n_q [W];
  logic [PW-1:0]   p_q [W];

  for (genvar s = 0; s < W; s++) begin : g_st
    logic [ExtW-1:0] r_in;
    logic [W-1:0]    n_in;
    logic [PW-1:0]   p_in;
    logic [ExtW:0]   t;
    logic [ExtW:0]   diff;
    logic            ge;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign n_in = dividend_i;
      assign p_in = pay_i;
    end else begin : g_next
      assign r_in = r_q[s-1];
      assign n_in = n_q[s-1];
      assign p_in = p_q[s-1];
    end

    // Shift in next dividend bit, subtract when it fits
    assign t    = {r_in, n_in[W-1]};
    assign diff = t - {1'b0, divisor_i};
    assign ge   = (t >= {1'b0, divisor_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= ge ? diff[ExtW-1:0] : t[ExtW-1:0];
        n_q[s] <= {n_in[W-2:0], ge};
        p_q[s] <= p_in;
      end
    end
  end

  assign quot_o = n_q[W-1];
  assign rem_o  = r_q[W-1];
  assign pay_o  = p_q[W-1];

endmodule

/* rtl/core/lcsi_lane.sv */
// One dimension lane: block quotients, digit remainders, and the outer remainder.
// Built from lcsi_div instances. Uses lcsi_pkg.
module lcsi_lane
  import lcsi_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [ExtW-1:0] x_i,
  input  logic [ExtW-1:0] rk_i,
  input  logic [ExtW-1:0] lo_i,
  input  logic [ExtW-1:0] inn_i,
  input  logic [ExtW-1:0] ou_i,
  output logic [ExtW-1:0] x_o,
  output logic [ExtW-1:0] r2_o,
  input  logic [ExtW:0]   c_i,
  input  logic            par_i,
  output logic [ExtW-1:0] om_o,
  output logic [ExtW-1:0] r1_o,
  output logic [ExtW-1:0] r2d_o,
  output logic            par_o
);

  logic [ExtW-1:0] q1, q2, xa, r1, r2;

  // Divide coordinate by local and outer extents
  lcsi_div #(.W(ExtW), .PW(ExtW)) u_div_lo (
    .clk_i, .en_i, .dividend_i(x_i), .divisor_i(lo_i), .pay_i(x_i),
    .quot_o(q1), .rem_o(), .pay_o(xa)
  );
  lcsi_div #(.W(ExtW), .PW(1)) u_div_ou (
    .clk_i, .en_i, .dividend_i(x_i), .divisor_i(ou_i), .pay_i(1'b0),
    .quot_o(q2), .rem_o(), .pay_o()
  );

  // Reduce quotients modulo rank and inner extents
  lcsi_div #(.W(ExtW), .PW(ExtW)) u_mod_rk (
    .clk_i, .en_i, .dividend_i(q1), .divisor_i(rk_i), .pay_i(xa),
    .quot_o(), .rem_o(r1), .pay_o(x_o)
  );
  lcsi_div #(.W(ExtW), .PW(1)) u_mod_in (
    .clk_i, .en_i, .dividend_i(q2), .divisor_i(inn_i), .pay_i(1'b0),
    .quot_o(), .rem_o(r2), .pay_o()
  );

  assign r2_o = r2;

  // Shifted coordinate modulo outer extent, carry digits alongside
  lcsi_div #(.W(ExtW+1), .PW(2*ExtW+1)) u_mod_ou (
    .clk_i, .en_i, .dividend_i(c_i), .divisor_i(ou_i), .pay_i({par_i, r1, r2}),
    .quot_o(), .rem_o(om_o), .pay_o({par_o, r1_o, r2d_o})
  );

endmodule

/* rtl/core/lcsi_merge.sv */
// Merging stage: lexicographic Horner sums over lanes, parity half and final index.
// Uses lcsi_pkg.
module lcsi_merge
  import lcsi_pkg::*;
#(
  parameter int unsigned ND = 4
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  cfg_t            cfg_i,
  input  logic [ExtW-1:0] r1_i [ND],
  input  logic [ExtW-1:0] r2_i [ND],
  input  logic [ExtW-1:0] om_i [ND],
  input  logic            par_i,
  output logic [15:0]     owner_rank_o,
  output logic [23:0]     site_index_o
);

  logic [15:0]     ri_q [ND];
  logic [23:0]     ii_q [ND];
  logic [24:0]     oi_q [ND];
  logic            par_q [ND];
  logic [ExtW-1:0] d1_q [ND][ND];
  logic [ExtW-1:0] d2_q [ND][ND];
  logic [ExtW-1:0] d3_q [ND][ND];

  logic [24:0] sum;
  logic [23:0] half_q, ii_f_q, site_q;
  logic [15:0] ri_f_q, rank_q;

  // Load slowest digits and hold all digits for later steps
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ri_q[0]  <= 16'(r1_i[ND-1]);
      ii_q[0]  <= 24'(r2_i[ND-1]);
      oi_q[0]  <= 25'(om_i[ND-1]);
      par_q[0] <= par_i;
      d1_q[0]  <= r1_i;
      d2_q[0]  <= r2_i;
      d3_q[0]  <= om_i;
    end
  end

  // Advance one dimension per stage: acc = acc * extent + digit
  for (genvar s = 1; s < ND; s++) begin : g_horner
    localparam int unsigned K = ND - 1 - s;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ri_q[s]  <= 16'(ri_q[s-1] * 16'(ext_of(cfg_i.rank_extents, K))
                        + 16'(d1_q[s-1][K]));
        ii_q[s]  <= 24'(ii_q[s-1] * 24'(ext_of(cfg_i.inner_extents, K))
                        + 24'(d2_q[s-1][K]));
        oi_q[s]  <= 25'(oi_q[s-1] * 25'(ext_of(cfg_i.outer_extents, K))
                        + 25'(d3_q[s-1][K]));
        par_q[s] <= par_q[s-1];
        d1_q[s]  <= d1_q[s-1];
        d2_q[s]  <= d2_q[s-1];
        d3_q[s]  <= d3_q[s-1];
      end
    end
  end

  // Odd sites go to the second half of the outer range
  assign sum = oi_q[ND-1] + (par_q[ND-1] ? cfg_i.outer_sites : 25'd0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      half_q <= sum[24:1];
      ri_f_q <= ri_q[ND-1];
      ii_f_q <= ii_q[ND-1];
      site_q <= 24'(half_q * 24'(cfg_i.inner_sites) + ii_f_q);
      rank_q <= ri_f_q;
    end
  end

  assign owner_rank_o = rank_q;
  assign site_index_o = site_q;

endmodule

/* rtl/core/lattice_coord_to_site_index.sv */
// Top level: maps a global lattice coordinate to owner rank and local site index.
// Uses lcsi_pkg, lcsi_lane and lcsi_merge.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+-----------------------------
//   in      | input     | in_valid_i/in_ready_o | in_beat_t  (coord_0..3)
//   out     | output    | out_valid_o/out_ready_i | out_beat_t (rank, index)
//   cfg     | input     | cfg_we_i, no wait     | cfg_idx_i, cfg_data_i
//
// One beat per cycle sustained while the output is not held; the datapath is built from three
// chained bit-serial divider pipelines (12, 12 and 13 stages) plus the Horner merge.
// Reset clears the valid pipeline and loads default extents; no clearing pass.
// A held output stalls the whole pipeline; input is taken whenever the output
// register is free or being drained in the same cycle.
module lattice_coord_to_site_index
  import lcsi_pkg::*;
#(
  parameter int unsigned NUM_DIMS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_beat_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_beat_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [PackW-1:0] cfg_data_i
);

  localparam int unsigned Lat = 3 * ExtW + 3 + NUM_DIMS;

  cfg_t            cfg_q;
  logic [Lat-1:0]  vld_q;
  logic            en;
  logic [ExtW-1:0] x_all [MaxDims];
  logic [ExtW-1:0] ou_ext [NUM_DIMS];
  logic [ExtW-1:0] x2 [NUM_DIMS];
  logic [ExtW-1:0] r2 [NUM_DIMS];
  logic [ExtW:0]   c [NUM_DIMS];
  logic [ExtW-1:0] om [NUM_DIMS];
  logic [ExtW-1:0] r1d [NUM_DIMS];
  logic [ExtW-1:0] r2d [NUM_DIMS];
  logic            pard [NUM_DIMS];
  logic            blk, par;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rank_extents  <= ExtReset;
      cfg_q.local_extents <= ExtReset;
      cfg_q.inner_extents <= ExtReset;
      cfg_q.outer_extents <= ExtReset;
      cfg_q.cb_shift      <= '0;
      cfg_q.cb_direction  <= '0;
      cfg_q.outer_sites   <= 25'd1;
      cfg_q.inner_sites   <= 13'd1;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RANK_EXT:  cfg_q.rank_extents  <= cfg_data_i;
        REG_LOCAL_EXT: cfg_q.local_extents <= cfg_data_i;
        REG_INNER_EXT: cfg_q.inner_extents <= cfg_data_i;
        REG_OUTER_EXT: cfg_q.outer_extents <= cfg_data_i;
        REG_CB_SHIFT:  cfg_q.cb_shift      <= cfg_data_i[10:0];
        REG_CB_DIR:    cfg_q.cb_direction  <= cfg_data_i[1:0];
        REG_OUTER_SZ:  cfg_q.outer_sites   <= cfg_data_i[24:0];
        REG_INNER_SZ:  cfg_q.inner_sites   <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless a finished beat is held
  assign en          = ~vld_q[Lat-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  assign x_all[0] = in_data_i.coord_0;
  assign x_all[1] = in_data_i.coord_1;
  assign x_all[2] = in_data_i.coord_2;
  assign x_all[3] = in_data_i.coord_3;

  for (genvar i = 0; i < NUM_DIMS; i++) begin : g_lane
    assign ou_ext[i] = ext_of(cfg_q.outer_extents, i);

    lcsi_lane u_lane (
      .clk_i,
      .en_i  (en),
      .x_i   (x_all[i]),
      .rk_i  (ext_of(cfg_q.rank_extents, i)),
      .lo_i  (ext_of(cfg_q.local_extents, i)),
      .inn_i (ext_of(cfg_q.inner_extents, i)),
      .ou_i  (ou_ext[i]),
      .x_o   (x2[i]),
      .r2_o  (r2[i]),
      .c_i   (c[i]),
      .par_i (par),
      .om_o  (om[i]),
      .r1_o  (r1d[i]),
      .r2d_o (r2d[i]),
      .par_o (pard[i])
    );
  end

  // Block parity, coordinate parity and checkerboard offset across lanes
  always_comb begin
    blk = 1'b0;
    par = 1'b0;
    for (int i = 0; i < NUM_DIMS; i++) begin
      blk = blk ^ (r2[i][0] & ou_ext[i][0]);
      par = par ^ x2[i][0];
    end
    for (int i = 0; i < NUM_DIMS; i++) begin
      c[i] = {1'b0, x2[i]};
      if (blk && (cfg_q.cb_direction == 2'(i))) begin
        c[i] = c[i] + {2'b00, cfg_q.cb_shift};
      end
    end
  end

  lcsi_merge #(.ND(NUM_DIMS)) u_merge (
    .clk_i,
    .en_i         (en),
    .cfg_i        (cfg_q),
    .r1_i         (r1d),
    .r2_i         (r2d),
    .om_i         (om),
    .par_i        (pard[0]),
    .owner_rank_o (out_data_o.owner_rank),
    .site_index_o (out_data_o.site_index)
  );

  // Hold the valid pipeline while stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("valid pipeline moved during stall");

  // Input is refused only behind a held result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o) else $error("input refused with empty output");

  // Accepted beat enters the first stage
  a_accept_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0]) else $error("accepted beat lost");

endmodule

/* dv/tb.sv */
// Testbench for lattice_coord_to_site_index: streams coordinate beats under random
// sender gaps and receiver stalls, predicts rank and site index, checks each result.
// Depends on lcsi_pkg and the RTL top level.
module tb;
  import lcsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Dims     = 4;
  localparam int unsigned Latency  = 39 + Dims;
  localparam longint      CycleCap = 400000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  in_beat_t         in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_beat_t        out_data_o;
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_idx_i = '0;
  logic [PackW-1:0] cfg_data_i = '0;

  lattice_coord_to_site_index #(.NUM_DIMS(Dims)) u_dut (.*);

  // Shadow copy of the mapping registers
  logic [PackW-1:0] rank_ext, local_ext, inner_ext, outer_ext;
  logic [10:0]      shift_amt;
  logic [1:0]       shift_dim;
  logic [24:0]      outer_cnt;
  logic [12:0]      lane_cnt;

  out_beat_t pending_sites[$];
  int        mismatches = 0;
  longint    cycles = 0;
  bit        stall_pattern_on = 1'b1;

  initial forever #6 clk_i = ~clk_i;

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint unsigned field_of(logic [PackW-1:0] p, int d);
    logic [11:0] e;
    e = p[12*d +: 12];
    return (e == 0) ? 1 : e;
  endfunction

  function automatic out_beat_t map_site(in_beat_t c);
    longint unsigned x[4];
    longint unsigned rk, lo, ie, ou, cc, half;
    longint unsigned rank_ix = 0, lane_ix = 0, outer_ix = 0, blk = 0, par = 0;
    out_beat_t r;
    x[0] = c.coord_0; x[1] = c.coord_1; x[2] = c.coord_2; x[3] = c.coord_3;
    for (int d = Dims - 1; d >= 0; d--) begin
      rk = field_of(rank_ext, d);
      lo = field_of(local_ext, d);
      ie = field_of(inner_ext, d);
      ou = field_of(outer_ext, d);
      rank_ix = rank_ix * rk + (x[d] / lo) % rk;
      lane_ix = lane_ix * ie + (x[d] / ou) % ie;
    end
    for (int d = 0; d < Dims; d++) begin
      ie = field_of(inner_ext, d);
      ou = field_of(outer_ext, d);
      blk += ((x[d] / ou) % ie) * ou;
      par += x[d];
    end
    blk &= 1;
    for (int d = Dims - 1; d >= 0; d--) begin
      ou = field_of(outer_ext, d);
      cc = x[d];
      if (d == shift_dim) cc += shift_amt * blk;
      outer_ix = outer_ix * ou + cc % ou;
    end
    half = par[0] ? (outer_ix + outer_cnt) / 2 : outer_ix / 2;
    r.owner_rank = rank_ix[15:0];
    r.site_index = 24'(half * lane_cnt + lane_ix);
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [PackW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_RANK_EXT:  rank_ext = val;
      REG_LOCAL_EXT: local_ext = val;
      REG_INNER_EXT: inner_ext = val;
      REG_OUTER_EXT: outer_ext = val;
      REG_CB_SHIFT:  shift_amt = val[10:0];
      REG_CB_DIR:    shift_dim = val[1:0];
      REG_OUTER_SZ:  outer_cnt = val[24:0];
      REG_INNER_SZ:  lane_cnt = val[12:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait for every expected beat to drain, then let the pipe settle
  task automatic drain();
    while (pending_sites.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  // Send one coordinate beat; valid stays high across back-to-back beats
  task automatic send_coord(in_beat_t c, bit hold_after);
    in_valid_i <= 1'b1;
    in_data_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_sites.push_back(map_site(c));
    @(negedge clk_i);
    if (!hold_after) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic in_beat_t rand_coord();
    in_beat_t c;
    c[31:0] = $urandom;
    c[47:32] = 16'($urandom);
    if ($urandom_range(0, 2) == 0) c.coord_0 = 12'($urandom_range(0, 15));
    return c;
  endfunction

  function automatic logic [PackW-1:0] rand_ext(int unsigned hi);
    logic [PackW-1:0] p;
    for (int d = 0; d < 4; d++)
      p[12*d +: 12] = ($urandom_range(0, 9) == 0) ? 12'(0) : 12'($urandom_range(1, hi));
    return p;
  endfunction

  // Send n beats in bursts with random gaps
  task automatic stream(int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      for (int k = 0; k < burst; k++) send_coord(rand_coord(), k != burst - 1);
      left -= burst;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  endtask

  task automatic test_reset_defaults();
    in_beat_t c;
    c = '0;
    send_coord(c, 1'b0);
    c = '1;
    send_coord(c, 1'b0);
    drain();
  endtask

  task automatic test_directed_extremes();
    in_beat_t c;
    write_reg(REG_RANK_EXT, 48'h002_003_004_005);
    write_reg(REG_LOCAL_EXT, 48'h008_008_008_008);
    write_reg(REG_INNER_EXT, 48'h002_001_002_002);
    write_reg(REG_OUTER_EXT, 48'h004_008_004_004);
    write_reg(REG_CB_SHIFT, 48'd1);
    write_reg(REG_CB_DIR, 48'd0);
    write_reg(REG_OUTER_SZ, 48'd512);
    write_reg(REG_INNER_SZ, 48'd8);
    for (int b = 0; b < 48; b += 4) begin
      c = '0;
      c[b] = 1'b1;
      send_coord(c, 1'b0);
    end
    c = '1;
    send_coord(c, 1'b0);
    c = {12'd1, 12'd2, 12'd3, 12'd5};
    send_coord(c, 1'b0);
    drain();
    // Direction on the highest dimension and zero extent fields
    write_reg(REG_CB_DIR, 48'd3);
    write_reg(REG_CB_SHIFT, 48'd2047);
    write_reg(REG_OUTER_EXT, 48'h000_FFF_000_7FF);
    write_reg(REG_INNER_EXT, 48'hFFF_000_FFF_001);
    write_reg(REG_OUTER_SZ, 48'h1FFFFFF);
    write_reg(REG_INNER_SZ, 48'h1FFF);
    for (int k = 0; k < 8; k++) send_coord(rand_coord(), k != 7);
    drain();
    write_reg(REG_RANK_EXT, 48'hFFF_FFF_FFF_FFF);
    write_reg(REG_LOCAL_EXT, 48'd0);
    c = '1;
    send_coord(c, 1'b0);
    drain();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 16; ph++) begin
      write_reg(REG_RANK_EXT, rand_ext(ph % 4 == 0 ? 4095 : 8));
      write_reg(REG_LOCAL_EXT, rand_ext(ph % 3 == 0 ? 4095 : 64));
      write_reg(REG_INNER_EXT, rand_ext(ph % 5 == 0 ? 4095 : 4));
      write_reg(REG_OUTER_EXT, rand_ext(ph % 2 == 0 ? 4095 : 32));
      write_reg(REG_CB_SHIFT, 48'($urandom_range(0, 2047)));
      write_reg(REG_CB_DIR, 48'($urandom_range(0, 3)));
      write_reg(REG_OUTER_SZ, 48'($urandom_range(0, 33554431)));
      write_reg(REG_INNER_SZ, 48'($urandom_range(0, 8191)));
      stall_pattern_on = (ph % 4 != 3);
      stream(100);
      drain();
    end
  endtask

  // Receiver: with the stall pattern on, stalls in a repeating pattern with random jitter; else always ready
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk_i);
      phase = (phase + 1) % 11;
      out_ready_i <= !stall_pattern_on ||
                     (phase < 7 && $urandom_range(0, 7) != 0);
    end
  end

  // Compare each result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_sites.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat rank=%0d idx=%0d",
                                       out_data_o.owner_rank, out_data_o.site_index);
      end else begin
        out_beat_t exp_b;
        exp_b = pending_sites.pop_front();
        if (out_data_o.owner_rank !== exp_b.owner_rank ||
            out_data_o.site_index !== exp_b.site_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch rank exp=%0d got=%0d idx exp=%0d got=%0d",
                     exp_b.owner_rank, out_data_o.owner_rank,
                     exp_b.site_index, out_data_o.site_index);
        end
      end
    end
  end

  initial begin
    rank_ext = ExtReset; local_ext = ExtReset;
    inner_ext = ExtReset; outer_ext = ExtReset;
    shift_amt = '0; shift_dim = '0; outer_cnt = 25'd1; lane_cnt = 13'd1;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_directed_extremes();
    test_random_settings();
    if (pending_sites.size() != 0) mismatches++;
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
